>>> hdl/mcr_pkg.sv
// Shared types, codes and defaults for the MIDI connection router.
package mcr_pkg;

	localparam int DEF_PORTS       = 8;
	localparam int DEF_CONNECTIONS = 16;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRESENT = 2'd0;
	localparam logic [1:0] CFG_OUTPUT  = 2'd1;
	localparam logic [1:0] CFG_RUNNING = 2'd2;

	// Result outcome codes
	localparam logic [2:0] OUT_ROUTED       = 3'd0;
	localparam logic [2:0] OUT_FILTERED     = 3'd1;
	localparam logic [2:0] OUT_DEST_ERROR   = 3'd2;
	localparam logic [2:0] OUT_NO_ROUTE     = 3'd3;
	localparam logic [2:0] OUT_SLOT_WRITTEN = 3'd4;
	localparam logic [2:0] OUT_NOT_RUNNING  = 3'd5;

	// Status high nibbles
	localparam logic [3:0] TYPE_NOTE_OFF    = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON     = 4'h9;
	localparam logic [3:0] TYPE_POLY_PRESS  = 4'hA;
	localparam logic [3:0] TYPE_CONTROL     = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM     = 4'hC;
	localparam logic [3:0] TYPE_CHAN_PRESS  = 4'hD;
	localparam logic [3:0] TYPE_BEND        = 4'hE;
	localparam logic [3:0] TYPE_SYSTEM      = 4'hF;

	// Filter bit positions
	localparam int FLT_NOTE     = 0;
	localparam int FLT_CONTROL  = 1;
	localparam int FLT_PROGRAM  = 2;
	localparam int FLT_BEND     = 3;
	localparam int FLT_SYSEX    = 4;
	localparam int FLT_REALTIME = 5;

	localparam logic [7:0] ANY_CHANNEL = 8'hFF;

	typedef struct packed {
		logic       func;
		logic [2:0] source_port;
		logic [7:0] status_byte;
		logic [7:0] data_one;
		logic [7:0] data_two;
		logic [3:0] slot_index;
		logic [2:0] slot_source;
		logic [2:0] slot_dest;
		logic [7:0] slot_src_channel;
		logic [7:0] slot_dst_channel;
		logic [5:0] slot_filter;
		logic       slot_enable;
	} cmd_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic [2:0] route_port;
		logic [7:0] status_out;
		logic [7:0] data_one_out;
		logic [7:0] data_two_out;
		logic [3:0] slot_used;
		logic       last_of_run;
	} result_t;

	// One connection slot as held in the table (enable lives in flops)
	typedef struct packed {
		logic [2:0] src;
		logic [2:0] dst;
		logic [7:0] src_ch;
		logic [7:0] dst_ch;
		logic [5:0] filter;
	} slot_t;

	typedef struct packed {
		logic [7:0] present;
		logic [7:0] outputs;
	} port_cfg_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic [7:0] status;
	} check_t;

endpackage

>>> hdl/midi_connection_router.sv
// Top level of the MIDI connection router: slot table, scan sequencer, result register.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------------
//  command   | in        | start, busy (taken: start&!busy) | cmd (mcr_pkg::cmd_t)
//  result    | out       | result_strobe, one cycle      | result (mcr_pkg::result_t)
//  config    | in        | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// A slot write or a route while stopped gives its single item in the cycle
// after start is taken and leaves busy low. A route holds busy while the slot
// table is read one slot per cycle through its single read port, then through
// a wait state for the read and a flush state for the final item. Items leave
// one per matching slot as the scan goes.
// Reset clears the configuration registers, the slot enables and all control.
// The receiver cannot stall; cfg_ready is always high.
module midi_connection_router #(
	parameter int PORTS       = mcr_pkg::DEF_PORTS,
	parameter int CONNECTIONS = mcr_pkg::DEF_CONNECTIONS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mcr_pkg::cmd_t    cmd,
	output logic             result_strobe,
	output mcr_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	localparam int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CONNECTIONS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [7:0] present_q;
	logic [7:0] outputs_q;
	logic       running_q;

	// Slot table: payload in memory, enables in flops
	mcr_pkg::slot_t   mem_q [CONNECTIONS];
	logic [CONNECTIONS-1:0] en_q;

	// Held message for the scan
	logic [2:0] src_q;
	logic [7:0] status_q;
	logic [7:0] data_one_q;
	logic [7:0] data_two_q;

	// Scan counter and read stage
	logic [IDX_W-1:0] cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_en_s1;
	mcr_pkg::slot_t   rd_slot_s1;

	// One result held back until we know whether it is the last
	mcr_pkg::result_t pend_q;
	logic             pend_vld_q;

	mcr_pkg::result_t out_q;
	logic             out_vld_q;

	logic             accept;
	logic             write_cmd;
	logic             slot_in_range;
	logic [IDX_W-1:0] waddr;
	logic             hit;
	mcr_pkg::check_t  chk;
	mcr_pkg::slot_t   wslot;
	mcr_pkg::result_t emit_res;
	logic             emit;
	mcr_pkg::port_cfg_t port_cfg;

	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign result        = out_q;
	assign result_strobe = out_vld_q;

	assign accept        = start && !busy;
	assign write_cmd     = accept && cmd.func;
	assign slot_in_range = (32'(cmd.slot_index) < CONNECTIONS);
	assign waddr         = IDX_W'(cmd.slot_index);

	assign wslot.src    = cmd.slot_source;
	assign wslot.dst    = cmd.slot_dest;
	assign wslot.src_ch = cmd.slot_src_channel;
	assign wslot.dst_ch = cmd.slot_dst_channel;
	assign wslot.filter = cmd.slot_filter;

	assign port_cfg.present = present_q;
	assign port_cfg.outputs = outputs_q;

	// Configuration writes; index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			outputs_q <= '0;
			running_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mcr_pkg::CFG_PRESENT: present_q <= cfg_data;
				mcr_pkg::CFG_OUTPUT:  outputs_q <= cfg_data;
				mcr_pkg::CFG_RUNNING: running_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Table payload: write on a slot command, read the scanned slot
	always_ff @(posedge clk) begin
		if (write_cmd && slot_in_range) begin
			mem_q[waddr] <= wslot;
		end
		rd_slot_s1 <= mem_q[cnt_q];
	end

	// Slot enables, cleared by reset so every slot starts disabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (write_cmd && slot_in_range) begin
			en_q[waddr] <= cmd.slot_enable;
		end
	end

	// Hold the message for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q      <= cmd.source_port;
			status_q   <= cmd.status_byte;
			data_one_q <= cmd.data_one;
			data_two_q <= cmd.data_two;
		end
		rd_idx_s1 <= cnt_q;
		rd_en_s1  <= en_q[cnt_q];
	end

	// Sequencer: advance one slot per cycle, then wait out the read, then flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && !cmd.func && running_q) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_WAIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WAIT: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Shared slot evaluation unit
	mcr_slot_check #(
		.PORTS(PORTS)
	) u_check (
		.slot   (rd_slot_s1),
		.status (status_q),
		.ports  (port_cfg),
		.check  (chk)
	);

	assign hit = rd_vld_s1 && rd_en_s1 && (rd_slot_s1.src == src_q);

	// Pick what leaves this cycle
	always_comb begin
		emit     = 1'b0;
		emit_res = pend_q;
		if (accept && cmd.func) begin
			emit                  = 1'b1;
			emit_res.outcome      = mcr_pkg::OUT_SLOT_WRITTEN;
			emit_res.route_port   = 3'd0;
			emit_res.status_out   = cmd.status_byte;
			emit_res.data_one_out = cmd.data_one;
			emit_res.data_two_out = cmd.data_two;
			emit_res.slot_used    = cmd.slot_index;
			emit_res.last_of_run  = 1'b1;
		end else if (accept && !running_q) begin
			emit                  = 1'b1;
			emit_res.outcome      = mcr_pkg::OUT_NOT_RUNNING;
			emit_res.route_port   = 3'd0;
			emit_res.status_out   = cmd.status_byte;
			emit_res.data_one_out = cmd.data_one;
			emit_res.data_two_out = cmd.data_two;
			emit_res.slot_used    = 4'd0;
			emit_res.last_of_run  = 1'b1;
		end else if (state_q == ST_FLUSH) begin
			emit                 = 1'b1;
			emit_res.last_of_run = 1'b1;
			if (!pend_vld_q) begin
				emit_res.outcome      = mcr_pkg::OUT_NO_ROUTE;
				emit_res.route_port   = 3'd0;
				emit_res.status_out   = status_q;
				emit_res.data_one_out = data_one_q;
				emit_res.data_two_out = data_two_q;
				emit_res.slot_used    = 4'd0;
			end
		end else if (hit && pend_vld_q) begin
			// a newer match proves the held item is not the last
			emit                 = 1'b1;
			emit_res.last_of_run = 1'b0;
		end
	end

	// Held result: replace on every match, drop after the flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (state_q == ST_FLUSH) begin
			pend_vld_q <= 1'b0;
		end else if (hit) begin
			pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			pend_q.outcome      <= chk.outcome;
			pend_q.route_port   <= rd_slot_s1.dst;
			pend_q.status_out   <= chk.status;
			pend_q.data_one_out <= data_one_q;
			pend_q.data_two_out <= data_two_q;
			pend_q.slot_used    <= 4'(rd_idx_s1);
			pend_q.last_of_run  <= 1'b0;
		end
	end

	// Result register: each item shows for exactly one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
	end

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_vld_q)
		else $error("held result left over while idle");

	a_last_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last_of_run) |-> !busy)
		else $error("final item shown while still busy");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last_of_run) |-> busy)
		else $error("non-final item with no scan in progress");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ((state_q == ST_SCAN) || (state_q == ST_WAIT)))
		else $error("slot read outside a scan");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.outcome <= mcr_pkg::OUT_NOT_RUNNING))
		else $error("unknown outcome code");
`endif

endmodule

>>> hdl/mcr_slot_check.sv
// Slot evaluation unit: filter, destination check and channel remap for one slot.
module mcr_slot_check #(
	parameter int PORTS = mcr_pkg::DEF_PORTS
) (
	input  mcr_pkg::slot_t     slot,
	input  logic [7:0]         status,
	input  mcr_pkg::port_cfg_t ports,
	output mcr_pkg::check_t    check
);

	logic type_hit;
	logic blocked;
	logic dest_bad;

	always_comb begin
		type_hit = 1'b0;
		case (status[7:4]) inside
			mcr_pkg::TYPE_NOTE_OFF, mcr_pkg::TYPE_NOTE_ON: begin
				type_hit = slot.filter[mcr_pkg::FLT_NOTE];
			end
			mcr_pkg::TYPE_CONTROL: begin
				type_hit = slot.filter[mcr_pkg::FLT_CONTROL];
			end
			mcr_pkg::TYPE_PROGRAM: begin
				type_hit = slot.filter[mcr_pkg::FLT_PROGRAM];
			end
			mcr_pkg::TYPE_BEND: begin
				type_hit = slot.filter[mcr_pkg::FLT_BEND];
			end
			mcr_pkg::TYPE_SYSTEM: begin
				// realtime bytes have bit 3 of the status set
				type_hit = status[3] ? slot.filter[mcr_pkg::FLT_REALTIME]
				                     : slot.filter[mcr_pkg::FLT_SYSEX];
			end
			default: begin
				type_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		blocked = (slot.filter != 6'd0) &&
		          (((slot.src_ch != mcr_pkg::ANY_CHANNEL) &&
		            ({4'd0, status[3:0]} != slot.src_ch)) || type_hit);
		dest_bad = (32'(slot.dst) >= PORTS) || !ports.present[slot.dst] ||
		           !ports.outputs[slot.dst];

		check.status = status;
		if (blocked) begin
			check.outcome = mcr_pkg::OUT_FILTERED;
		end else if (dest_bad) begin
			check.outcome = mcr_pkg::OUT_DEST_ERROR;
		end else begin
			check.outcome = mcr_pkg::OUT_ROUTED;
			if ((slot.dst_ch != mcr_pkg::ANY_CHANNEL) && (status[7:4] != mcr_pkg::TYPE_SYSTEM)) begin
				check.status = {status[7:4], slot.dst_ch[3:0]};
			end
		end
	end

endmodule
